// ----- rtl/core/vertex_dedup_indexer_macros.svh -----
`ifndef VERTEX_DEDUP_INDEXER_MACROS_SVH
`define VERTEX_DEDUP_INDEXER_MACROS_SVH

// same-cycle implication
`define VDI_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define VDI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/core/vdi_pkg.sv -----
package vdi_pkg;

	localparam int unsigned KEY_W = 256;

	typedef struct packed {
		logic        first_of_mesh;
		logic [31:0] pos_x;
		logic [31:0] pos_y;
		logic [31:0] pos_z;
		logic [31:0] tex_u;
		logic [31:0] tex_v;
		logic [31:0] norm_x;
		logic [31:0] norm_y;
		logic [31:0] norm_z;
	} vtx_in_t;

	typedef struct packed {
		logic [7:0] vertex_index;
		logic       is_new;
		logic       overflow;
	} vtx_out_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_LAST
	} state_t;

	typedef logic [KEY_W-1:0] key_t;

	function automatic key_t key_of(vtx_in_t v);
		return {v.norm_z, v.norm_y, v.norm_x, v.tex_v, v.tex_u, v.pos_z, v.pos_y, v.pos_x};
	endfunction

endpackage

// ----- rtl/core/vdi_key_ram.sv -----
module vdi_key_ram #(
	parameter int unsigned DEPTH = 256,
	parameter int unsigned AW    = 8
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  vdi_pkg::key_t    wdata,
	input  logic [AW-1:0]    raddr,
	output vdi_pkg::key_t    rdata
);

	vdi_pkg::key_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// ----- rtl/core/vertex_dedup_indexer.sv -----
// channel | signals                  | transfer
// input   | start, busy, vertex      | start high while busy low
// output  | done, result             | done high, one cycle, always taken
//
// an item's key is compared against the entries stored in the mesh so far, one stored
// key per cycle through the key memory's single read port; a hit ends the search
// early
// reset clears the entry count and control; key storage is not cleared
// the receiver cannot stall: done is high for one cycle only
`include "vertex_dedup_indexer_macros.svh"

module vertex_dedup_indexer #(
	parameter int unsigned TABLE_DEPTH = 256
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  vdi_pkg::vtx_in_t  vertex,
	output logic              done,
	output vdi_pkg::vtx_out_t result
);

	localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
	localparam int unsigned XW = AW + 8;

	vdi_pkg::state_t  state_q, state_nx;
	vdi_pkg::key_t    key_q;
	vdi_pkg::key_t    rd_data;
	logic [CW-1:0]    count_q;
	logic [AW-1:0]    ptr_q;
	logic             valid_s1;
	logic [AW-1:0]    idx_s1;
	logic             done_q;
	vdi_pkg::vtx_out_t result_q;

	logic             accept;
	logic             hit;
	logic             full;
	logic             last_rd;
	logic             do_insert;
	logic             do_over;
	logic [XW-1:0]    hit_idx_x;
	logic [XW-1:0]    new_idx_x;

	assign accept = start && (state_q == vdi_pkg::ST_IDLE);
	assign busy   = (state_q != vdi_pkg::ST_IDLE);
	assign done   = done_q;
	assign result = result_q;

	assign full      = (count_q == CW'(TABLE_DEPTH));
	assign hit       = valid_s1 && (rd_data == key_q);
	assign last_rd   = (CW'(ptr_q) == (count_q - CW'(1)));
	assign hit_idx_x = XW'(idx_s1);
	assign new_idx_x = XW'(count_q);

	vdi_key_ram #(
		.DEPTH (TABLE_DEPTH),
		.AW    (AW)
	) u_key_ram (
		.clk   (clk),
		.we    (do_insert),
		.waddr (count_q[AW-1:0]),
		.wdata (key_q),
		.raddr (ptr_q),
		.rdata (rd_data)
	);

	always_comb begin
		state_nx = state_q;
		case (state_q)
			vdi_pkg::ST_IDLE: begin
				if (accept) begin
					if (vertex.first_of_mesh || (count_q == '0)) begin
						state_nx = vdi_pkg::ST_LAST;
					end else begin
						state_nx = vdi_pkg::ST_SEARCH;
					end
				end
			end
			vdi_pkg::ST_SEARCH: begin
				if (hit) begin
					state_nx = vdi_pkg::ST_IDLE;
				end else if (last_rd) begin
					state_nx = vdi_pkg::ST_LAST;
				end
			end
			vdi_pkg::ST_LAST: begin
				state_nx = vdi_pkg::ST_IDLE;
			end
			default: begin
				state_nx = vdi_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		do_insert = 1'b0;
		do_over   = 1'b0;
		case (state_q)
			vdi_pkg::ST_LAST: begin
				do_insert = !hit && !full;
				do_over   = !hit && full;
			end
			default: begin
				do_insert = 1'b0;
				do_over   = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= vdi_pkg::ST_IDLE;
			count_q  <= '0;
			ptr_q    <= '0;
			valid_s1 <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			state_q  <= state_nx;
			valid_s1 <= (state_q == vdi_pkg::ST_SEARCH) && !hit;
			done_q   <= hit || do_insert || do_over;
			if (accept) begin
				ptr_q <= '0;
				if (vertex.first_of_mesh) begin
					count_q <= '0;
				end
			end else if (state_q == vdi_pkg::ST_SEARCH) begin
				ptr_q <= ptr_q + AW'(1);
			end
			if (do_insert) begin
				count_q <= count_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= ptr_q;
		if (accept) begin
			key_q <= vdi_pkg::key_of(vertex);
		end
		if (hit) begin
			result_q.vertex_index <= hit_idx_x[7:0];
			result_q.is_new       <= 1'b0;
			result_q.overflow     <= 1'b0;
		end else if (do_insert) begin
			result_q.vertex_index <= new_idx_x[7:0];
			result_q.is_new       <= 1'b1;
			result_q.overflow     <= 1'b0;
		end else if (do_over) begin
			result_q.vertex_index <= '0;
			result_q.is_new       <= 1'b0;
			result_q.overflow     <= 1'b1;
		end
	end

	`VDI_ASSERT_NOW(a_flags_excl, clk, arst_n, done, !(result.is_new && result.overflow), "both flags")
	`VDI_ASSERT_NEXT(a_done_single, clk, arst_n, done_q, !done_q, "back-to-back results")
	`VDI_ASSERT_NEXT(a_accept_busy, clk, arst_n, accept, busy, "not busy after transfer")
	`VDI_ASSERT_NOW(a_count_bound, clk, arst_n, 1'b1, count_q <= CW'(TABLE_DEPTH), "count past depth")

endmodule
